/* hdl/wnms_pkg.sv */
package wnms_pkg;

	// command codes on cmd
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_RUN  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// result kinds
	localparam logic KIND_RUN  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// reset value of the overlap threshold, Q0.16
	localparam logic [15:0] THR_RESET = 16'd19661;

	// cycles from a stable box pair to a valid overlap flag
	localparam int OV_LAT = 5;

	// number of box coordinates at the head of each detection
	localparam int BOX_COORDS = 4;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RK_KEY0,
		ST_RK_KEY1,
		ST_RK_RD,
		ST_RK_CMP,
		ST_RK_WR,
		ST_M_CHK,
		ST_M_ORD,
		ST_F_RD,
		ST_F_LD,
		ST_A_RD,
		ST_A_MUL,
		ST_A_ACC,
		ST_J_CHK,
		ST_J_ORD,
		ST_OV_WAIT,
		ST_M_FIN,
		ST_D_RD,
		ST_D_WAIT,
		ST_DONE
	} state_t;

	// which slot addresses the score and coordinate stores
	typedef enum logic [1:0] {
		SEL_I,
		SEL_J,
		SEL_LEAD,
		SEL_OTHER
	} slot_sel_t;

	typedef struct packed {
		logic      load_we;
		logic      rd_req;
		logic      run_done;
		logic      run_init;
		logic      rank_clr;
		logic      rank_cmp;
		logic      key_ld;
		logic      ord_wr;
		logic      ord_rd_j;
		logic      lead_ld;
		logic      other_ld;
		logic      box_ld;
		logic      acc_wr;
		logic      acc_first;
		logic      wsum_init;
		logic      wsum_add;
		logic      used_set_i;
		logic      used_set_j;
		logic      div_start;
		logic      out_score_wr;
		logic      out_coord_wr;
		logic      kept_inc;
		slot_sel_t slot_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic used_i;
		logic used_j;
		logic overlap;
		logic div_done;
	} dp_stat_t;

endpackage

/* hdl/wnms_div.sv */
module wnms_div import wnms_pkg::*; #(
	parameter int DW = 38,
	parameter int VW = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0]   rem_w;
	logic [VW:0]   diff;

	// one restoring step: shift in next dividend bit, trial subtract
	assign rem_w = {rem_q, quo_q[DW-1]};
	assign diff  = rem_w - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!diff[VW]) begin
				rem_q <= diff[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_w[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hdl/wnms_ctrl.sv */
module wnms_ctrl import wnms_pkg::*; #(
	parameter int MAX_DETS       = 64,
	parameter int COORDS_PER_DET = 18
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [1:0]                          cmd,
	input  logic [6:0]                          det_count,
	output logic                                busy,
	output dp_cmd_t                             dp_cmd,
	output logic [$clog2(MAX_DETS+1)-1:0]       i_idx,
	output logic [$clog2(MAX_DETS+1)-1:0]       j_idx,
	output logic [$clog2(COORDS_PER_DET):0]     c_idx,
	input  dp_stat_t                            dp_stat
);

	localparam int CW  = $clog2(MAX_DETS + 1);
	localparam int CNW = $clog2(COORDS_PER_DET) + 1;

	state_t         state_q, state_d;
	logic [CW-1:0]  i_q, i_d, j_q, j_d, n_q, n_d;
	logic [CNW-1:0] c_q, c_d;
	logic           tgt_q, tgt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			n_q     <= '0;
			c_q     <= '0;
			tgt_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			n_q     <= n_d;
			c_q     <= c_d;
			tgt_q   <= tgt_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		n_d     = n_q;
		c_d     = c_q;
		tgt_d   = tgt_q;
		dp_cmd  = '0;
		dp_cmd.slot_sel = tgt_q ? SEL_OTHER : SEL_LEAD;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd)
						CMD_LOAD: dp_cmd.load_we = 1'b1;
						CMD_READ: dp_cmd.rd_req = 1'b1;
						CMD_RUN: begin
							if (32'(det_count) > MAX_DETS) begin
								n_d = CW'(MAX_DETS);
							end else begin
								n_d = CW'(det_count);
							end
							i_d = '0;
							dp_cmd.run_init = 1'b1;
							state_d = (det_count == 7'd0) ? ST_DONE : ST_RK_KEY0;
						end
						default: ;
					endcase
				end
			end
			// rank pass: count how many slots precede slot i in sorted order
			ST_RK_KEY0: begin
				dp_cmd.slot_sel = SEL_I;
				state_d = ST_RK_KEY1;
			end
			ST_RK_KEY1: begin
				dp_cmd.slot_sel = SEL_I;
				dp_cmd.key_ld   = 1'b1;
				dp_cmd.rank_clr = 1'b1;
				j_d     = '0;
				state_d = ST_RK_RD;
			end
			ST_RK_RD: begin
				dp_cmd.slot_sel = SEL_J;
				state_d = ST_RK_CMP;
			end
			ST_RK_CMP: begin
				dp_cmd.slot_sel = SEL_J;
				dp_cmd.rank_cmp = 1'b1;
				if (j_q + 1'b1 == n_q) begin
					state_d = ST_RK_WR;
				end else begin
					j_d     = j_q + 1'b1;
					state_d = ST_RK_RD;
				end
			end
			ST_RK_WR: begin
				dp_cmd.ord_wr = 1'b1;
				if (i_q + 1'b1 == n_q) begin
					i_d     = '0;
					state_d = ST_M_CHK;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ST_RK_KEY0;
				end
			end
			// merge pass: pick next unused leader
			ST_M_CHK: begin
				if (i_q == n_q) begin
					state_d = ST_DONE;
				end else if (dp_stat.used_i) begin
					i_d = i_q + 1'b1;
				end else begin
					state_d = ST_M_ORD;
				end
			end
			ST_M_ORD: begin
				dp_cmd.lead_ld = 1'b1;
				tgt_d   = 1'b0;
				c_d     = '0;
				state_d = ST_F_RD;
			end
			// fetch score and box of leader or candidate
			ST_F_RD: state_d = ST_F_LD;
			ST_F_LD: begin
				dp_cmd.box_ld = 1'b1;
				if (c_q == CNW'(BOX_COORDS - 1)) begin
					c_d = '0;
					if (tgt_q) begin
						state_d = ST_OV_WAIT;
					end else begin
						dp_cmd.wsum_init = 1'b1;
						state_d = ST_A_RD;
					end
				end else begin
					c_d     = c_q + 1'b1;
					state_d = ST_F_RD;
				end
			end
			// weighted accumulate, one coordinate at a time: read, multiply, accumulate
			ST_A_RD:  state_d = ST_A_MUL;
			ST_A_MUL: state_d = ST_A_ACC;
			ST_A_ACC: begin
				dp_cmd.acc_wr    = 1'b1;
				dp_cmd.acc_first = !tgt_q;
				if (c_q == CNW'(COORDS_PER_DET - 1)) begin
					j_d     = tgt_q ? j_q + 1'b1 : i_q + 1'b1;
					state_d = ST_J_CHK;
				end else begin
					c_d     = c_q + 1'b1;
					state_d = ST_A_RD;
				end
			end
			// next unused candidate after the leader
			ST_J_CHK: begin
				dp_cmd.ord_rd_j = 1'b1;
				if (j_q == n_q) begin
					state_d = ST_M_FIN;
				end else if (dp_stat.used_j) begin
					j_d = j_q + 1'b1;
				end else begin
					state_d = ST_J_ORD;
				end
			end
			ST_J_ORD: begin
				dp_cmd.other_ld = 1'b1;
				tgt_d   = 1'b1;
				c_d     = '0;
				state_d = ST_F_RD;
			end
			// wait for the overlap pipeline, then absorb or skip
			ST_OV_WAIT: begin
				if (c_q == CNW'(OV_LAT)) begin
					c_d = '0;
					if (dp_stat.overlap) begin
						dp_cmd.used_set_j = 1'b1;
						dp_cmd.wsum_add   = 1'b1;
						state_d = ST_A_RD;
					end else begin
						j_d     = j_q + 1'b1;
						state_d = ST_J_CHK;
					end
				end else begin
					c_d = c_q + 1'b1;
				end
			end
			// write merged detection
			ST_M_FIN: begin
				dp_cmd.out_score_wr = 1'b1;
				dp_cmd.used_set_i   = 1'b1;
				c_d     = '0;
				state_d = ST_D_RD;
			end
			ST_D_RD: begin
				dp_cmd.slot_sel  = SEL_LEAD;
				dp_cmd.div_start = 1'b1;
				state_d = ST_D_WAIT;
			end
			ST_D_WAIT: begin
				dp_cmd.slot_sel = SEL_LEAD;
				if (dp_stat.div_done) begin
					dp_cmd.out_coord_wr = 1'b1;
					if (c_q == CNW'(COORDS_PER_DET - 1)) begin
						dp_cmd.kept_inc = 1'b1;
						i_d     = i_q + 1'b1;
						state_d = ST_M_CHK;
					end else begin
						c_d     = c_q + 1'b1;
						state_d = ST_D_RD;
					end
				end
			end
			ST_DONE: begin
				dp_cmd.run_done = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy  = (state_q != ST_IDLE);
	assign i_idx = i_q;
	assign j_idx = j_q;
	assign c_idx = c_q;

endmodule

/* hdl/wnms_dp.sv */
module wnms_dp import wnms_pkg::*; #(
	parameter int MAX_DETS       = 64,
	parameter int COORDS_PER_DET = 18
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dp_cmd_t                         dp_cmd,
	input  logic [$clog2(MAX_DETS+1)-1:0]   i_idx,
	input  logic [$clog2(MAX_DETS+1)-1:0]   j_idx,
	input  logic [$clog2(COORDS_PER_DET):0] c_idx,
	output dp_stat_t                        dp_stat,
	input  logic [5:0]                      det_index,
	input  logic [4:0]                      coord_index,
	input  logic signed [15:0]              coord_value,
	input  logic [15:0]                     score_in,
	input  logic                            cfg_wen,
	input  logic [15:0]                     cfg_wdata,
	output logic                            result_valid,
	output logic                            result_kind,
	output logic [6:0]                      kept_count,
	output logic [15:0]                     score_out,
	output logic signed [15:0]              coord_out,
	output logic                            read_error
);

	localparam int CW    = $clog2(MAX_DETS + 1);
	localparam int IW    = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
	localparam int CIW   = $clog2(COORDS_PER_DET);
	localparam int DEPTH = MAX_DETS * COORDS_PER_DET;
	localparam int AW    = $clog2(DEPTH);
	localparam int ACC_W = 33 + $clog2(MAX_DETS);
	localparam int DVW   = ACC_W - 1;
	localparam int WS_W  = 16 + $clog2(MAX_DETS);

	// stores
	logic [15:0]        score_mem  [MAX_DETS];
	logic signed [15:0] coord_mem  [DEPTH];
	logic [IW-1:0]      order_mem  [MAX_DETS];
	logic [15:0]        oscore_mem [MAX_DETS];
	logic signed [15:0] ocoord_mem [DEPTH];
	logic [MAX_DETS-1:0] used_q;

	logic [15:0]        thr_q;
	logic [CW-1:0]      kept_q;
	logic [IW-1:0]      lead_q, other_q;
	logic [15:0]        lead_score_q, other_score_q;
	logic signed [15:0] lb_q [BOX_COORDS];
	logic signed [15:0] ob_q [BOX_COORDS];
	logic [15:0]        key_q;
	logic [IW-1:0]      rank_q;
	logic [WS_W-1:0]    wsum_q;
	logic signed [ACC_W-1:0] acc_q [COORDS_PER_DET];
	logic               neg_q;

	logic [15:0]        sc_rdata_q;
	logic signed [15:0] cd_rdata_q;
	logic [IW-1:0]      ord_rdata_q;

	logic [IW-1:0]      slot;
	logic [AW-1:0]      rd_addr;
	logic [CIW-1:0]     ci;
	logic [15:0]        score_sel;

	assign ci = c_idx[CIW-1:0];

	// slot for the score and coordinate read port
	always_comb begin
		unique case (dp_cmd.slot_sel)
			SEL_I:     slot = i_idx[IW-1:0];
			SEL_J:     slot = j_idx[IW-1:0];
			SEL_LEAD:  slot = lead_q;
			SEL_OTHER: slot = other_q;
			default:   slot = lead_q;
		endcase
	end

	assign rd_addr   = AW'(AW'(slot) * AW'(COORDS_PER_DET) + AW'(ci));
	assign score_sel = (dp_cmd.slot_sel == SEL_OTHER) ? other_score_q : lead_score_q;

	// input stores: written by load, read by the run sequence
	always_ff @(posedge clk) begin
		if (dp_cmd.load_we && (32'(det_index) < MAX_DETS) &&
				(32'(coord_index) < COORDS_PER_DET)) begin
			coord_mem[AW'(32'(det_index) * COORDS_PER_DET + 32'(coord_index))] <= coord_value;
			if (coord_index == 5'd0) begin
				score_mem[IW'(det_index)] <= score_in;
			end
		end
		sc_rdata_q <= score_mem[slot];
		cd_rdata_q <= coord_mem[rd_addr];
	end

	// sorted order store
	always_ff @(posedge clk) begin
		if (dp_cmd.ord_wr) begin
			order_mem[rank_q] <= i_idx[IW-1:0];
		end
		ord_rdata_q <= order_mem[dp_cmd.ord_rd_j ? j_idx[IW-1:0] : i_idx[IW-1:0]];
	end

	// threshold, kept count, used flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			kept_q <= '0;
			used_q <= '0;
		end else begin
			if (cfg_wen) begin
				thr_q <= cfg_wdata;
			end
			if (dp_cmd.run_init) begin
				kept_q <= '0;
				used_q <= '0;
			end else begin
				if (dp_cmd.kept_inc) begin
					kept_q <= kept_q + 1'b1;
				end
				if (dp_cmd.used_set_i) begin
					used_q[i_idx[IW-1:0]] <= 1'b1;
				end
				if (dp_cmd.used_set_j) begin
					used_q[j_idx[IW-1:0]] <= 1'b1;
				end
			end
		end
	end

	assign dp_stat.used_i = used_q[i_idx[IW-1:0]];
	assign dp_stat.used_j = used_q[j_idx[IW-1:0]];

	// rank count: stable descending order
	always_ff @(posedge clk) begin
		if (dp_cmd.key_ld) begin
			key_q <= sc_rdata_q;
		end
		if (dp_cmd.rank_clr) begin
			rank_q <= '0;
		end else if (dp_cmd.rank_cmp) begin
			if ((sc_rdata_q > key_q) || ((sc_rdata_q == key_q) && (j_idx < i_idx))) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	// leader and candidate registers
	always_ff @(posedge clk) begin
		if (dp_cmd.lead_ld) begin
			lead_q <= ord_rdata_q;
		end
		if (dp_cmd.other_ld) begin
			other_q <= ord_rdata_q;
		end
		if (dp_cmd.box_ld) begin
			if (dp_cmd.slot_sel == SEL_OTHER) begin
				ob_q[ci[1:0]] <= cd_rdata_q;
				other_score_q <= sc_rdata_q;
			end else begin
				lb_q[ci[1:0]] <= cd_rdata_q;
				lead_score_q  <= sc_rdata_q;
			end
		end
		if (dp_cmd.wsum_init) begin
			wsum_q <= WS_W'(lead_score_q);
		end else if (dp_cmd.wsum_add) begin
			wsum_q <= wsum_q + WS_W'(other_score_q);
		end
	end

	// overlap pipeline, runs every cycle off the box registers
	logic signed [15:0] y1, x1, y2, x2;
	logic signed [16:0] dy, dx;
	logic [15:0]        dy_s1, dx_s1;
	logic signed [16:0] ha_s1, wa_s1, hb_s1, wb_s1;
	logic [31:0]        inter_s2, inter_s3, inter_s4;
	logic signed [33:0] aa_s2, ab_s2;
	logic signed [35:0] uni_s3;
	logic               pos_s4;
	logic [32:0]        plo_s4, phi_s4;
	logic               ovl_s5;

	assign y1 = (lb_q[0] > ob_q[0]) ? lb_q[0] : ob_q[0];
	assign x1 = (lb_q[1] > ob_q[1]) ? lb_q[1] : ob_q[1];
	assign y2 = (lb_q[2] < ob_q[2]) ? lb_q[2] : ob_q[2];
	assign x2 = (lb_q[3] < ob_q[3]) ? lb_q[3] : ob_q[3];
	assign dy = 17'(y2) - 17'(y1);
	assign dx = 17'(x2) - 17'(x1);

	always_ff @(posedge clk) begin
		dy_s1    <= (dy > 17'sd0) ? dy[15:0] : 16'd0;
		dx_s1    <= (dx > 17'sd0) ? dx[15:0] : 16'd0;
		ha_s1    <= 17'(lb_q[2]) - 17'(lb_q[0]);
		wa_s1    <= 17'(lb_q[3]) - 17'(lb_q[1]);
		hb_s1    <= 17'(ob_q[2]) - 17'(ob_q[0]);
		wb_s1    <= 17'(ob_q[3]) - 17'(ob_q[1]);
		inter_s2 <= 32'(dy_s1) * 32'(dx_s1);
		aa_s2    <= 34'(ha_s1) * 34'(wa_s1);
		ab_s2    <= 34'(hb_s1) * 34'(wb_s1);
		uni_s3   <= 36'(aa_s2) + 36'(ab_s2) - $signed(36'(inter_s2));
		inter_s3 <= inter_s2;
		pos_s4   <= (uni_s3 > 36'sd0);
		plo_s4   <= 33'(thr_q) * 33'(uni_s3[16:0]);
		phi_s4   <= 33'(thr_q) * 33'(uni_s3[33:17]);
		inter_s4 <= inter_s3;
		ovl_s5   <= pos_s4 &&
			(50'({inter_s4, 16'd0}) > (50'({phi_s4, 17'd0}) + 50'(plo_s4)));
	end

	assign dp_stat.overlap = ovl_s5;

	// weighted accumulate
	logic signed [16:0] sc_ext;
	logic signed [32:0] prod_s1;

	assign sc_ext = {1'b0, score_sel};

	always_ff @(posedge clk) begin
		prod_s1 <= 33'(cd_rdata_q) * 33'(sc_ext);
		if (dp_cmd.acc_wr) begin
			if (dp_cmd.acc_first) begin
				acc_q[ci] <= ACC_W'(prod_s1);
			end else begin
				acc_q[ci] <= acc_q[ci] + ACC_W'(prod_s1);
			end
		end
	end

	// weighted mean: divide magnitude, restore sign, saturate
	logic signed [ACC_W-1:0] acc_sel;
	logic [ACC_W-1:0]        acc_mag;
	logic [DVW-1:0]          quo;
	logic                    div_done;
	logic signed [15:0]      mean;
	logic signed [15:0]      merged;

	assign acc_sel = acc_q[ci];
	assign acc_mag = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);

	wnms_div #(
		.DW (DVW),
		.VW (WS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dp_cmd.div_start),
		.dividend (acc_mag[DVW-1:0]),
		.divisor  (wsum_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign dp_stat.div_done = div_done;

	always_ff @(posedge clk) begin
		if (dp_cmd.div_start) begin
			neg_q <= acc_sel[ACC_W-1];
		end
	end

	always_comb begin
		if (!neg_q) begin
			mean = (quo > DVW'(32767)) ? 16'sh7fff : $signed(quo[15:0]);
		end else begin
			mean = (quo >= DVW'(32768)) ? 16'sh8000 : $signed(16'(~quo[15:0] + 16'd1));
		end
		// zero weight group keeps the leader's own coordinate
		merged = (wsum_q == '0) ? cd_rdata_q : mean;
	end

	// result stores
	logic                 res_valid_q, res_kind_q, res_err_q;
	logic [15:0]          os_rdata_q;
	logic signed [15:0]   oc_rdata_q;

	always_ff @(posedge clk) begin
		if (dp_cmd.out_score_wr) begin
			oscore_mem[kept_q[IW-1:0]] <= lead_score_q;
		end
		if (dp_cmd.out_coord_wr) begin
			ocoord_mem[AW'(AW'(kept_q[IW-1:0]) * AW'(COORDS_PER_DET) + AW'(ci))] <= merged;
		end
		if (dp_cmd.rd_req) begin
			os_rdata_q <= oscore_mem[IW'(det_index)];
			oc_rdata_q <= ocoord_mem[AW'(32'(det_index) * COORDS_PER_DET + 32'(coord_index))];
			res_err_q  <= !((32'(det_index) < 32'(kept_q)) && (32'(det_index) < MAX_DETS) &&
				(32'(coord_index) < COORDS_PER_DET));
		end
		if (dp_cmd.run_done) begin
			res_err_q <= 1'b0;
		end
		if (dp_cmd.rd_req || dp_cmd.run_done) begin
			res_kind_q <= dp_cmd.rd_req ? KIND_READ : KIND_RUN;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= dp_cmd.rd_req || dp_cmd.run_done;
		end
	end

	assign result_valid = res_valid_q;
	assign result_kind  = res_kind_q;
	assign kept_count   = 7'(kept_q);
	assign read_error   = res_err_q;
	assign score_out    = (res_kind_q == KIND_READ && !res_err_q) ? os_rdata_q : 16'd0;
	assign coord_out    = (res_kind_q == KIND_READ && !res_err_q) ? oc_rdata_q : 16'sd0;

endmodule

/* hdl/weighted_nms_merge_unit.sv */
// Channel   Direction  Handshake                Payload
// command   in         start & !busy            cmd det_index coord_index coord_value
//                                               score_in det_count
// config    in         cfg_wen                  cfg_wdata (overlap threshold)
// result    out        result_valid, 1 cycle    result_kind kept_count score_out
//                                               coord_out read_error
//
// Load gives no result; a read result is strobed the cycle after accept.
// Run holds busy through rank counting, an overlap test per candidate box, a
// weighted accumulate per absorbed detection, and per leader a division of every
// coordinate by the one-bit-a-step divider (38 steps at 64 slots).
// Reset clears the threshold to its default, the kept count and the used flags.
// Results cannot be held off by the receiver; each strobe lasts one cycle.
module weighted_nms_merge_unit import wnms_pkg::*; #(
	parameter int MAX_DETS       = 64,
	parameter int COORDS_PER_DET = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic [5:0]         det_index,
	input  logic [4:0]         coord_index,
	input  logic signed [15:0] coord_value,
	input  logic [15:0]        score_in,
	input  logic [6:0]         det_count,
	input  logic               cfg_wen,
	input  logic [15:0]        cfg_wdata,
	output logic               result_valid,
	output logic               result_kind,
	output logic [6:0]         kept_count,
	output logic [15:0]        score_out,
	output logic signed [15:0] coord_out,
	output logic               read_error
);

	localparam int CW  = $clog2(MAX_DETS + 1);
	localparam int CNW = $clog2(COORDS_PER_DET) + 1;

	dp_cmd_t        dp_cmd;
	dp_stat_t       dp_stat;
	logic [CW-1:0]  i_idx, j_idx;
	logic [CNW-1:0] c_idx;

	wnms_ctrl #(
		.MAX_DETS       (MAX_DETS),
		.COORDS_PER_DET (COORDS_PER_DET)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.det_count (det_count),
		.busy      (busy),
		.dp_cmd    (dp_cmd),
		.i_idx     (i_idx),
		.j_idx     (j_idx),
		.c_idx     (c_idx),
		.dp_stat   (dp_stat)
	);

	wnms_dp #(
		.MAX_DETS       (MAX_DETS),
		.COORDS_PER_DET (COORDS_PER_DET)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_cmd       (dp_cmd),
		.i_idx        (i_idx),
		.j_idx        (j_idx),
		.c_idx        (c_idx),
		.dp_stat      (dp_stat),
		.det_index    (det_index),
		.coord_index  (coord_index),
		.coord_value  (coord_value),
		.score_in     (score_in),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result_kind  (result_kind),
		.kept_count   (kept_count),
		.score_out    (score_out),
		.coord_out    (coord_out),
		.read_error   (read_error)
	);

endmodule

/* hdl/wnms_chk.sv */
module wnms_chk import wnms_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         cmd,
	input logic               result_valid,
	input logic               result_kind,
	input logic [15:0]        score_out,
	input logic signed [15:0] coord_out,
	input logic               read_error
);

	// a read transaction is answered in the next cycle
	a_read_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_READ) |=> (result_valid && result_kind == KIND_READ))
		else $error("read transaction not answered");

	// a load transaction gives no result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_LOAD) |=> !result_valid)
		else $error("load transaction gave a result");

	// results only appear when the block is free again
	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result while busy");

	// run results and refused reads carry zero data
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result_kind == KIND_RUN || read_error)) |->
			(score_out == 16'd0 && coord_out == 16'sd0))
		else $error("nonzero data on run result or refused read");

	// a run finish never flags a read error
	a_run_noerr: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == KIND_RUN) |-> !read_error)
		else $error("read error on run result");

endmodule

bind weighted_nms_merge_unit wnms_chk u_wnms_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.cmd          (cmd),
	.result_valid (result_valid),
	.result_kind  (result_kind),
	.score_out    (score_out),
	.coord_out    (coord_out),
	.read_error   (read_error)
);
